>>> rtl/nppl_pkg.sv
// Shared types, codes and constants for the Newell polygon plane block.
package nppl_pkg;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [15:0] center_x;
		logic signed [15:0] center_y;
		logic signed [15:0] center_z;
		logic [1:0]         status;
	} result_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DEGEN    = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam int FRAC_SHIFT = 30;
	localparam int RES_W      = 15;
	localparam logic [3:0] TOP_BIT = 4'd14;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_ACC,
		OP_CLOSE,
		OP_DIV,
		OP_CSET,
		OP_MUL_SQ,
		OP_TOTADD,
		OP_RHSSET,
		OP_MUL_TT,
		OP_MUL_TOT,
		OP_CMP,
		OP_SAVE,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] idx;
		logic [3:0] bit_pos;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic div_busy;
		logic overflow;
		logic zero_normal;
		logic cand_big;
		logic out_busy;
	} dp_status_t;

endpackage

>>> rtl/newell_polygon_plane.sv
// Top level of the Newell polygon plane block: controller plus datapath.
//
// Vertices arrive on the in channel (in_valid/in_ready/in_data), one transfer
// per vertex, as signed Q8.8 coordinates; last_point closes the polygon.
// One result per polygon leaves on the out channel (out_valid/out_ready/
// out_data): the unit normal in Q1.14, the centroid in Q8.8 and a status.
// An ordinary vertex registers an edge product per axis, then adds them
// into the sums. The last vertex is followed by the closing edge, three
// serial centroid divisions, three squares and, per normal component, one
// square and up to fifteen trial bits; each trial uses the one shared
// bit-serial multiplier twice. An overflow skips straight to the result,
// and so does a zero normal once the divisions are done.
// The result sits in an output register; the next polygon's vertices are
// taken while it waits, and a stalled receiver only holds the block at the
// end of the following polygon. Reset clears all sums and drops any result.
module newell_polygon_plane #(
	parameter int MAX_POINTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  nppl_pkg::point_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output nppl_pkg::result_t out_data
);
	import nppl_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	nppl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_data.last_point),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	nppl_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_ready (out_ready),
		.status    (status),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

>>> rtl/nppl_datapath.sv
// Datapath: vertex accumulators, serial multiplier, serial divider and result register.
module nppl_datapath #(
	parameter int MAX_POINTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nppl_pkg::point_t    in_data,
	input  nppl_pkg::dp_cmd_t   cmd,
	input  logic                out_ready,
	output nppl_pkg::dp_status_t status,
	output logic                out_valid,
	output nppl_pkg::result_t   out_data
);
	import nppl_pkg::*;

	localparam int KW  = $clog2(MAX_POINTS + 2);
	localparam int CW  = 17 + $clog2(MAX_POINTS + 1);
	localparam int NW  = 34 + $clog2(MAX_POINTS + 1);
	localparam int TW  = 2 * NW + 2;
	localparam int PW  = 2 * NW + 32;
	localparam int DCW = $clog2(CW + 1);
	localparam logic [KW-1:0] CNT_MAX = KW'(MAX_POINTS);
	localparam logic [KW-1:0] CNT_SAT = KW'(MAX_POINTS + 1);

	logic signed [15:0]   first_q [3];
	logic signed [15:0]   prev_q [3];
	logic signed [NW-1:0] nsum_q [3];
	logic signed [CW-1:0] csum_q [3];
	logic [KW-1:0]        count_q;
	logic signed [33:0]   prod_s1 [3];
	logic                 edge_s1;

	logic [PW-1:0]  ma_q, mp_q;
	logic [NW-1:0]  mb_q;
	logic           mul_busy_q;

	logic [CW-1:0]  dq_q;
	logic [KW-1:0]  rem_q;
	logic [DCW-1:0] dcnt_q;
	logic           div_busy_q;

	logic [TW-1:0]      total_q;
	logic [PW-1:0]      rhs_q;
	logic [RES_W-1:0]   res_q;
	logic signed [15:0] normal_q [3];
	logic signed [15:0] center_q [3];
	logic               out_valid_q;
	result_t            out_q;

	logic signed [15:0]   vin [3];
	logic signed [15:0]   eb [3];
	logic signed [33:0]   eprod [3];
	logic [KW-1:0]        next_cnt;
	logic                 take;
	logic signed [NW-1:0] nsel;
	logic [NW-1:0]        nmag;
	logic signed [CW-1:0] csel;
	logic [CW-1:0]        cmag;
	logic [RES_W-1:0]     cand;
	logic [15:0]          tval;
	logic [KW:0]          trial;
	logic [KW:0]          tdiff;
	logic                 tge;
	logic                 overflow;
	logic                 zero_normal;

	function automatic logic signed [33:0] edge_term(
		input logic signed [15:0] aj,
		input logic signed [15:0] bj,
		input logic signed [15:0] ak,
		input logic signed [15:0] bk
	);
		logic signed [16:0] d;
		logic signed [16:0] s;
		d = $signed({aj[15], aj}) - $signed({bj[15], bj});
		s = $signed({ak[15], ak}) + $signed({bk[15], bk});
		return 34'(d * s);
	endfunction

	assign vin[0] = in_data.point_x;
	assign vin[1] = in_data.point_y;
	assign vin[2] = in_data.point_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			eb[i] = (cmd.op == OP_CLOSE) ? first_q[i] : vin[i];
		end
		eprod[0] = edge_term(prev_q[1], eb[1], prev_q[2], eb[2]);
		eprod[1] = edge_term(prev_q[2], eb[2], prev_q[0], eb[0]);
		eprod[2] = edge_term(prev_q[0], eb[0], prev_q[1], eb[1]);
	end

	assign next_cnt = (count_q == CNT_SAT) ? count_q : count_q + 1'b1;
	assign take     = (next_cnt <= CNT_MAX);

	assign nsel = nsum_q[cmd.idx];
	assign nmag = nsel[NW-1] ? NW'(-nsel) : NW'(nsel);
	assign csel = csum_q[cmd.idx];
	assign cmag = csel[CW-1] ? CW'(-csel) : CW'(csel);
	assign cand = res_q | (RES_W'(1) << cmd.bit_pos);
	assign tval = {cand, 1'b0} - 16'd1;

	assign trial = {rem_q, dq_q[CW-1]};
	assign tdiff = trial - {1'b0, count_q};
	assign tge   = (trial >= {1'b0, count_q});

	assign overflow    = (count_q > CNT_MAX);
	assign zero_normal = (nsum_q[0] == '0) && (nsum_q[1] == '0) && (nsum_q[2] == '0);

	assign status.mul_busy    = mul_busy_q;
	assign status.div_busy    = div_busy_q;
	assign status.overflow    = overflow;
	assign status.zero_normal = zero_normal;
	assign status.cand_big    = res_q[RES_W-1];
	assign status.out_busy    = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				first_q[i]  <= '0;
				prev_q[i]   <= '0;
				nsum_q[i]   <= '0;
				csum_q[i]   <= '0;
				prod_s1[i]  <= '0;
				normal_q[i] <= '0;
				center_q[i] <= '0;
			end
			count_q     <= '0;
			edge_s1     <= 1'b0;
			ma_q        <= '0;
			mp_q        <= '0;
			mb_q        <= '0;
			mul_busy_q  <= 1'b0;
			dq_q        <= '0;
			rem_q       <= '0;
			dcnt_q      <= '0;
			div_busy_q  <= 1'b0;
			total_q     <= '0;
			rhs_q       <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (mul_busy_q) begin
				if (mb_q[0]) begin
					mp_q <= mp_q + ma_q;
				end
				ma_q <= ma_q << 1;
				mb_q <= mb_q >> 1;
				if (mb_q[NW-1:1] == '0) begin
					mul_busy_q <= 1'b0;
				end
			end
			if (div_busy_q) begin
				rem_q  <= tge ? tdiff[KW-1:0] : trial[KW-1:0];
				dq_q   <= {dq_q[CW-2:0], tge};
				dcnt_q <= dcnt_q - 1'b1;
				if (dcnt_q == DCW'(1)) begin
					div_busy_q <= 1'b0;
				end
			end
			if (out_valid_q && out_ready && (cmd.op != OP_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_LOAD: begin
					for (int i = 0; i < 3; i++) begin
						prod_s1[i] <= eprod[i];
					end
					edge_s1 <= take && (count_q != '0);
					if (take) begin
						for (int i = 0; i < 3; i++) begin
							if (count_q == '0) begin
								first_q[i] <= vin[i];
							end
							prev_q[i] <= vin[i];
							csum_q[i] <= csum_q[i] + CW'(vin[i]);
						end
					end
					count_q <= next_cnt;
				end
				OP_ACC: begin
					if (edge_s1) begin
						for (int i = 0; i < 3; i++) begin
							nsum_q[i] <= nsum_q[i] + NW'(prod_s1[i]);
						end
					end
				end
				OP_CLOSE: begin
					for (int i = 0; i < 3; i++) begin
						prod_s1[i]  <= eprod[i];
						normal_q[i] <= '0;
						center_q[i] <= '0;
					end
					edge_s1 <= 1'b1;
					total_q <= '0;
				end
				OP_DIV: begin
					dq_q       <= cmag;
					rem_q      <= '0;
					dcnt_q     <= DCW'(CW);
					div_busy_q <= 1'b1;
				end
				OP_CSET: begin
					center_q[cmd.idx] <= csel[CW-1] ? -(16'(dq_q)) : 16'(dq_q);
				end
				OP_MUL_SQ: begin
					ma_q       <= PW'(nmag);
					mb_q       <= nmag;
					mp_q       <= '0;
					mul_busy_q <= 1'b1;
				end
				OP_TOTADD: begin
					total_q <= total_q + mp_q[TW-1:0];
				end
				OP_RHSSET: begin
					rhs_q <= mp_q << FRAC_SHIFT;
					res_q <= '0;
				end
				OP_MUL_TT: begin
					ma_q       <= PW'(tval);
					mb_q       <= NW'(tval);
					mp_q       <= '0;
					mul_busy_q <= 1'b1;
				end
				OP_MUL_TOT: begin
					ma_q       <= PW'(total_q);
					mb_q       <= NW'(mp_q[FRAC_SHIFT-1:0]);
					mp_q       <= '0;
					mul_busy_q <= 1'b1;
				end
				OP_CMP: begin
					if (mp_q <= rhs_q) begin
						res_q <= cand;
					end
				end
				OP_SAVE: begin
					normal_q[cmd.idx] <= nsel[NW-1] ? -(16'(res_q)) : 16'(res_q);
				end
				OP_FIN: begin
					out_valid_q    <= 1'b1;
					out_q.normal_x <= normal_q[0];
					out_q.normal_y <= normal_q[1];
					out_q.normal_z <= normal_q[2];
					out_q.center_x <= center_q[0];
					out_q.center_y <= center_q[1];
					out_q.center_z <= center_q[2];
					out_q.status   <= overflow ? ST_OVERFLOW : (zero_normal ? ST_DEGEN : ST_OK);
					for (int i = 0; i < 3; i++) begin
						first_q[i] <= '0;
						prev_q[i]  <= '0;
						nsum_q[i]  <= '0;
						csum_q[i]  <= '0;
					end
					count_q <= '0;
				end
				default: ;
			endcase
		end
	end

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_busy_q && div_busy_q))
		else $error("multiplier and divider busy together");

	a_fin_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FIN) |=> out_valid_q)
		else $error("result not presented after finish");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_SAT)
		else $error("vertex count past saturation");

endmodule

>>> rtl/nppl_ctrl.sv
// Controller: sequences accumulation, closing edge, centroid division and normalization.
module nppl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_last,
	output logic                 in_ready,
	input  nppl_pkg::dp_status_t status,
	output nppl_pkg::dp_cmd_t    cmd
);
	import nppl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACC,
		S_CLOSE,
		S_CACC,
		S_DIV_GO,
		S_DIV_WAIT,
		S_SQ_GO,
		S_SQ_WAIT,
		S_RHS_GO,
		S_RHS_WAIT,
		S_BIT,
		S_TT_WAIT,
		S_TOT_WAIT,
		S_SAVE,
		S_FIN
	} state_t;

	state_t     state_q;
	logic [1:0] idx_q;
	logic [3:0] bit_q;
	logic       last_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.op      = OP_NONE;
		cmd.idx     = idx_q;
		cmd.bit_pos = bit_q;
		case (state_q)
			S_IDLE:     if (in_valid) cmd.op = OP_LOAD;
			S_ACC:      cmd.op = OP_ACC;
			S_CLOSE:    cmd.op = OP_CLOSE;
			S_CACC:     cmd.op = OP_ACC;
			S_DIV_GO:   cmd.op = OP_DIV;
			S_DIV_WAIT: if (!status.div_busy) cmd.op = OP_CSET;
			S_SQ_GO:    cmd.op = OP_MUL_SQ;
			S_SQ_WAIT:  if (!status.mul_busy) cmd.op = OP_TOTADD;
			S_RHS_GO:   cmd.op = OP_MUL_SQ;
			S_RHS_WAIT: if (!status.mul_busy) cmd.op = OP_RHSSET;
			S_BIT:      if (!status.cand_big) cmd.op = OP_MUL_TT;
			S_TT_WAIT:  if (!status.mul_busy) cmd.op = OP_MUL_TOT;
			S_TOT_WAIT: if (!status.mul_busy) cmd.op = OP_CMP;
			S_SAVE:     cmd.op = OP_SAVE;
			S_FIN:      if (!status.out_busy) cmd.op = OP_FIN;
			default:    cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			bit_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q  <= in_last;
						state_q <= S_ACC;
					end
				end
				S_ACC: state_q <= last_q ? S_CLOSE : S_IDLE;
				S_CLOSE: state_q <= S_CACC;
				S_CACC: begin
					idx_q   <= '0;
					state_q <= status.overflow ? S_FIN : S_DIV_GO;
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (!status.div_busy) begin
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							state_q <= status.zero_normal ? S_FIN : S_SQ_GO;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_SQ_GO: state_q <= S_SQ_WAIT;
				S_SQ_WAIT: begin
					if (!status.mul_busy) begin
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							state_q <= S_RHS_GO;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_SQ_GO;
						end
					end
				end
				S_RHS_GO: state_q <= S_RHS_WAIT;
				S_RHS_WAIT: begin
					if (!status.mul_busy) begin
						bit_q   <= TOP_BIT;
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					if (!status.cand_big) begin
						state_q <= S_TT_WAIT;
					end else if (bit_q == '0) begin
						state_q <= S_SAVE;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				S_TT_WAIT: if (!status.mul_busy) state_q <= S_TOT_WAIT;
				S_TOT_WAIT: begin
					if (!status.mul_busy) begin
						if (bit_q == '0) begin
							state_q <= S_SAVE;
						end else begin
							bit_q   <= bit_q - 1'b1;
							state_q <= S_BIT;
						end
					end
				end
				S_SAVE: begin
					if (idx_q == 2'd2) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RHS_GO;
					end
				end
				S_FIN: if (!status.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the Newell polygon plane block: normal, centroid and status.
module tb;
	import nppl_pkg::*;

	class plane_scoreboard;
		result_t   expected_q[$];
		int        errors;
		int        results_seen;
		int        status_count[3];
		int        first_vertex[3];
		int        prev_vertex[3];
		longint    normal_sum[3];
		longint    coord_sum[3];
		int        vertex_count;

		function new();
			errors = 0;
			results_seen = 0;
			status_count = '{0, 0, 0};
			clear_polygon();
		endfunction

		function void clear_polygon();
			first_vertex = '{0, 0, 0};
			prev_vertex = '{0, 0, 0};
			normal_sum = '{0, 0, 0};
			coord_sum = '{0, 0, 0};
			vertex_count = 0;
		endfunction

		function void add_edge(int a[3], int b[3]);
			normal_sum[0] += longint'(a[1] - b[1]) * longint'(a[2] + b[2]);
			normal_sum[1] += longint'(a[2] - b[2]) * longint'(a[0] + b[0]);
			normal_sum[2] += longint'(a[0] - b[0]) * longint'(a[1] + b[1]);
		endfunction

		function bit [127:0] square_mag(longint s);
			bit [127:0] m;
			m = (s < 0) ? 128'(-s) : 128'(s);
			return m * m;
		endfunction

		function logic signed [15:0] unit_component(longint s, bit [127:0] total);
			bit [127:0] rhs;
			bit [127:0] t;
			int         q;
			int         cand;
			rhs = square_mag(s) << 30;
			q = 0;
			for (int b = 14; b >= 0; b--) begin
				cand = q | (1 << b);
				if (cand <= 16384) begin
					t = 128'(2 * cand - 1);
					if (total * t * t <= rhs)
						q = cand;
				end
			end
			return (s < 0) ? 16'(-q) : 16'(q);
		endfunction

		function void note_vertex(point_t p);
			int         v[3];
			result_t    r;
			bit [127:0] total;
			v = '{int'(p.point_x), int'(p.point_y), int'(p.point_z)};
			if (vertex_count < 64) begin
				if (vertex_count == 0)
					first_vertex = v;
				else
					add_edge(prev_vertex, v);
				for (int i = 0; i < 3; i++)
					coord_sum[i] += v[i];
				prev_vertex = v;
			end
			if (vertex_count < 65)
				vertex_count++;
			if (!p.last_point)
				return;
			r = '0;
			if (vertex_count > 64) begin
				r.status = ST_OVERFLOW;
			end else begin
				add_edge(prev_vertex, first_vertex);
				r.center_x = 16'(coord_sum[0] / vertex_count);
				r.center_y = 16'(coord_sum[1] / vertex_count);
				r.center_z = 16'(coord_sum[2] / vertex_count);
				if (normal_sum[0] == 0 && normal_sum[1] == 0 && normal_sum[2] == 0) begin
					r.status = ST_DEGEN;
				end else begin
					r.status = ST_OK;
					total = square_mag(normal_sum[0]) + square_mag(normal_sum[1])
						+ square_mag(normal_sum[2]);
					r.normal_x = unit_component(normal_sum[0], total);
					r.normal_y = unit_component(normal_sum[1], total);
					r.normal_z = unit_component(normal_sum[2], total);
				end
			end
			expected_q.push_back(r);
			clear_polygon();
		endfunction

		task report(string what, int got, int want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_result(result_t r);
			result_t e;
			if (expected_q.size() == 0) begin
				report("unexpected result, status", r.status, -1);
				return;
			end
			e = expected_q.pop_front();
			results_seen++;
			if (e.status <= ST_OVERFLOW)
				status_count[e.status]++;
			if (r.normal_x !== e.normal_x) report("normal_x", r.normal_x, e.normal_x);
			if (r.normal_y !== e.normal_y) report("normal_y", r.normal_y, e.normal_y);
			if (r.normal_z !== e.normal_z) report("normal_z", r.normal_z, e.normal_z);
			if (r.center_x !== e.center_x) report("center_x", r.center_x, e.center_x);
			if (r.center_y !== e.center_y) report("center_y", r.center_y, e.center_y);
			if (r.center_z !== e.center_z) report("center_z", r.center_z, e.center_z);
			if (r.status !== e.status) report("status", r.status, e.status);
		endtask
	endclass

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	point_t  in_data;
	logic    out_valid;
	logic    out_ready;
	result_t out_data;
	bit      quiet;
	int      vertices_sent;

	plane_scoreboard board;

	newell_polygon_plane u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_vertex(in_data);
		if (arst_n && out_valid && out_ready)
			board.check_result(out_data);
	end

	task send_vertex(int x, int y, int z, bit last_flag);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{point_x: 16'(x), point_y: 16'(y), point_z: 16'(z), last_point: last_flag};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		vertices_sent++;
	endtask

	task send_polygon(int n, int spread);
		int px;
		int py;
		int pz;
		int mode;
		mode = $urandom_range(0, 9);
		px = $urandom_range(0, 200) - 100;
		py = $urandom_range(0, 200) - 100;
		pz = $urandom_range(0, 200) - 100;
		for (int i = 0; i < n; i++) begin
			if (mode == 0)
				send_vertex(px, py, pz, i == n - 1);
			else if (mode == 1)
				send_vertex(px + i * 7, py + i * 3, pz - i * 5, i == n - 1);
			else if (mode == 2)
				send_vertex($urandom_range(0, 2 * spread) - spread,
					$urandom_range(0, 2 * spread) - spread, pz, i == n - 1);
			else if (mode < 6)
				send_vertex($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
					$urandom_range(0, 65535) - 32768, i == n - 1);
			else
				send_vertex($urandom_range(0, 2 * spread) - spread,
					$urandom_range(0, 2 * spread) - spread,
					$urandom_range(0, 2 * spread) - spread, i == n - 1);
		end
	endtask

	task wait_drained();
		while (board.expected_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		int n;
		int roll;
		board = new();
		quiet = 1'b0;
		vertices_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_vertex(32767, 32767, 32767, 1'b1);
		send_vertex(-32768, -32768, -32768, 1'b1);
		send_vertex(0, 0, 0, 1'b0);
		send_vertex(256, 0, 0, 1'b0);
		send_vertex(0, 256, 0, 1'b1);
		send_vertex(32767, -32768, 32767, 1'b0);
		send_vertex(-32768, 32767, -32768, 1'b0);
		send_vertex(32767, 32767, -32768, 1'b1);
		send_vertex(100, 200, 300, 1'b0);
		send_vertex(200, 400, 600, 1'b0);
		send_vertex(-100, -200, -300, 1'b1);
		send_vertex(-32768, -32768, 0, 1'b0);
		send_vertex(32767, -32768, 0, 1'b0);
		send_vertex(32767, 32767, 0, 1'b0);
		send_vertex(-32768, 32767, 0, 1'b1);
		send_vertex(0, -32768, 32767, 1'b0);
		send_vertex(0, 32767, -32768, 1'b0);
		send_vertex(1, 1, 1, 1'b1);

		in_valid <= 1'b0;
		wait_drained();
		send_polygon(64, 32767);
		send_polygon(65, 1000);
		send_polygon(70, 32767);

		while (vertices_sent < 1650) begin
			if (vertices_sent > 1450)
				quiet = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 8)
				n = 1;
			else if (roll < 12)
				n = $urandom_range(60, 70);
			else if (roll < 20)
				n = 2;
			else
				n = $urandom_range(3, 9);
			send_polygon(n, (roll % 2) ? 32767 : 400);
		end
		in_valid <= 1'b0;
		wait_drained();
		repeat (3000) @(posedge clk);
		$display("%0d vertices sent, %0d polygons checked", vertices_sent, board.results_seen);
		$display("status ok %0d, degenerate %0d, overflow %0d", board.status_count[0],
			board.status_count[1], board.status_count[2]);
		if (board.errors == 0 && board.expected_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		int gap;
		@(posedge arst_n);
		out_ready <= 1'b1;
		forever begin
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				gap = $urandom_range(1, 11);
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#40000000;
		$display("simulation failed");
		$finish;
	end
endmodule
